// File: sv/pc_pkg.sv
package pc_pkg;

    localparam int MAX_VERTS = 64;
    localparam int MAX_CLIP  = 16;
    localparam int COORD_W   = 16;
    localparam int VA_W      = $clog2(MAX_VERTS);
    localparam int VC_W      = $clog2(MAX_VERTS + 1);
    localparam int CA_W      = $clog2(MAX_CLIP);
    localparam int CC_W      = $clog2(MAX_CLIP + 1);
    localparam int PT_W      = 2 * COORD_W;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int OPA_W     = 2 * COORD_W + 2;
    localparam int PROD_W    = OPA_W + DIFF_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int DEN_W     = 2 * DIFF_W + 2;
    localparam int Q_W       = COORD_W + 2;
    localparam int DIV_W     = DEN_W + Q_W - 1;
    localparam int DCNT_W    = $clog2(Q_W + 1);

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_pt;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_SHORT = 2'd2,
        ST_OVF   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        M_SIDE, M_P12, M_P34, M_DEN, M_NX, M_NY
    } t_mop;

    typedef enum logic [1:0] {
        WS_IN, WS_PK, WS_XP
    } t_wsrc;

    typedef enum logic [2:0] {
        CAP_NONE, CAP_S0, CAP_S1, CAP_S2, CAP_C0, CAP_C1, CAP_C2
    } t_cap;

    typedef enum logic [2:0] {
        LD_NONE, LD_EA, LD_EB, LD_CCW_S, LD_CCW_C, LD_PK, LD_PI
    } t_ld;

    typedef enum logic [4:0] {
        S_IDLE, S_CHK, S_SIDE, S_REVS, S_REVC, S_EDGE, S_EA, S_EB, S_P0,
        S_V, S_VK, S_DEC, S_XMAC, S_XDIV_CHK, S_XDIV, S_XW, S_KEEP,
        S_EEND, S_FIN, S_ORD, S_OLD, S_OST, S_OWT
    } t_state;

    typedef struct packed {
        logic            wr_a;
        logic            wr_b;
        logic            wr_c;
        logic [VA_W-1:0] waddr;
        logic [CA_W-1:0] cwaddr;
        t_wsrc           wsrc;
        logic [VA_W-1:0] raddr;
        logic [CA_W-1:0] caddr;
        logic            cur_b;
        t_cap            cap;
        t_ld             ld;
        logic            mac_en;
        logic            mac_sec;
        t_mop            mop;
        logic            div_start;
        logic            out_load;
        t_status         out_stat;
        logic            out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic kin;
        logic iin;
        logic den_zero;
        logic div_done;
    } t_dp_stat;

endpackage

// File: sv/pc_if.sv
interface pc_in_if;
    logic                              valid;
    logic                              ready;
    logic                              operation;
    logic signed [pc_pkg::COORD_W-1:0] x;
    logic signed [pc_pkg::COORD_W-1:0] y;
    logic                              last;

    modport source (output valid, operation, x, y, last, input ready);
    modport sink (input valid, operation, x, y, last, output ready);
endinterface

interface pc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [pc_pkg::COORD_W-1:0] x_res;
    logic signed [pc_pkg::COORD_W-1:0] y_res;
    logic                              last_res;
    logic [1:0]                        status;

    modport source (output valid, x_res, y_res, last_res, status, input ready);
    modport sink (input valid, x_res, y_res, last_res, status, output ready);
endinterface

// File: sv/pc_ram.sv
module pc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/pc_datapath.sv
module pc_datapath (
    input  logic                              i_clk,
    input  pc_pkg::t_dp_cmd                   i_cmd,
    input  logic signed [pc_pkg::COORD_W-1:0] i_x,
    input  logic signed [pc_pkg::COORD_W-1:0] i_y,
    output pc_pkg::t_dp_stat                  o_stat,
    output logic signed [pc_pkg::COORD_W-1:0] o_x_res,
    output logic signed [pc_pkg::COORD_W-1:0] o_y_res,
    output logic                              o_last_res,
    output logic [1:0]                        o_status
);
    import pc_pkg::*;

    function automatic logic signed [DIFF_W-1:0] sub17(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

    function automatic logic signed [COORD_W-1:0] sat16(
        input logic [Q_W-1:0] q,
        input logic           neg
    );
        logic signed [Q_W:0] v;
        v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (v > $signed((Q_W+1)'(32767))) begin
            return COORD_W'(32767);
        end else if (v < -$signed((Q_W+1)'(32768))) begin
            return COORD_W'(-32768);
        end
        return v[COORD_W-1:0];
    endfunction

    t_pt rd_a, rd_b, rd_c, cur_rd, wdata, xp;
    t_pt r_s0, r_s1, r_s2, r_c0, r_c1, r_c2;
    t_pt r_ea, r_eb, r_pi, r_pk;
    logic r_kin, r_iin;

    logic signed [OPA_W-1:0]  mac_a;
    logic signed [DIFF_W-1:0] mac_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  res;
    logic signed [ACC_W-1:0]  r_acc, r_nx, r_ny;
    logic signed [OPA_W-1:0]  r_p12, r_p34;
    logic signed [DEN_W-1:0]  r_den;

    logic [ACC_W-1:0]  nx_abs, ny_abs;
    logic [DEN_W-1:0]  den_abs;
    logic [DIV_W-1:0]  r_rx, r_ry, r_d;
    logic [Q_W-1:0]    r_qx, r_qy;
    logic              r_negx, r_negy;
    logic [DCNT_W-1:0] r_dcnt;
    logic              gex, gey;

    logic signed [COORD_W-1:0] r_ox, r_oy;
    logic                      r_olast;
    t_status                   r_ostat;

    pc_ram #(.WIDTH(PT_W), .DEPTH(MAX_VERTS)) u_work_a (
        .i_clk(i_clk), .i_we(i_cmd.wr_a), .i_waddr(i_cmd.waddr), .i_wdata(wdata),
        .i_raddr(i_cmd.raddr), .o_rdata(rd_a)
    );

    pc_ram #(.WIDTH(PT_W), .DEPTH(MAX_VERTS)) u_work_b (
        .i_clk(i_clk), .i_we(i_cmd.wr_b), .i_waddr(i_cmd.waddr), .i_wdata(wdata),
        .i_raddr(i_cmd.raddr), .o_rdata(rd_b)
    );

    pc_ram #(.WIDTH(PT_W), .DEPTH(MAX_CLIP)) u_clip (
        .i_clk(i_clk), .i_we(i_cmd.wr_c), .i_waddr(i_cmd.cwaddr), .i_wdata(wdata),
        .i_raddr(i_cmd.caddr), .o_rdata(rd_c)
    );

    assign cur_rd = i_cmd.cur_b ? rd_b : rd_a;
    assign xp     = '{x: sat16(r_qx, r_negx), y: sat16(r_qy, r_negy)};

    always_comb begin
        unique case (i_cmd.wsrc)
            WS_IN:   wdata = '{x: i_x, y: i_y};
            WS_PK:   wdata = r_pk;
            WS_XP:   wdata = xp;
            default: wdata = r_pk;
        endcase
    end

    always_comb begin
        unique case (i_cmd.mop)
            M_SIDE: begin
                mac_a = i_cmd.mac_sec ? OPA_W'(sub17(r_eb.y, r_ea.y))
                                      : OPA_W'(sub17(r_eb.x, r_ea.x));
                mac_b = i_cmd.mac_sec ? sub17(r_pk.x, r_ea.x) : sub17(r_pk.y, r_ea.y);
            end
            M_P12: begin
                mac_a = i_cmd.mac_sec ? OPA_W'(r_ea.y) : OPA_W'(r_ea.x);
                mac_b = i_cmd.mac_sec ? DIFF_W'(r_eb.x) : DIFF_W'(r_eb.y);
            end
            M_P34: begin
                mac_a = i_cmd.mac_sec ? OPA_W'(r_pi.y) : OPA_W'(r_pi.x);
                mac_b = i_cmd.mac_sec ? DIFF_W'(r_pk.x) : DIFF_W'(r_pk.y);
            end
            M_DEN: begin
                mac_a = i_cmd.mac_sec ? OPA_W'(sub17(r_ea.y, r_eb.y))
                                      : OPA_W'(sub17(r_ea.x, r_eb.x));
                mac_b = i_cmd.mac_sec ? sub17(r_pi.x, r_pk.x) : sub17(r_pi.y, r_pk.y);
            end
            M_NX: begin
                mac_a = i_cmd.mac_sec ? r_p34 : r_p12;
                mac_b = i_cmd.mac_sec ? sub17(r_ea.x, r_eb.x) : sub17(r_pi.x, r_pk.x);
            end
            M_NY: begin
                mac_a = i_cmd.mac_sec ? r_p34 : r_p12;
                mac_b = i_cmd.mac_sec ? sub17(r_ea.y, r_eb.y) : sub17(r_pi.y, r_pk.y);
            end
            default: begin
                mac_a = '0;
                mac_b = '0;
            end
        endcase
    end

    assign prod    = mac_a * mac_b;
    assign res     = r_acc - ACC_W'(prod);
    assign nx_abs  = r_nx[ACC_W-1] ? ACC_W'(-r_nx) : ACC_W'(r_nx);
    assign ny_abs  = r_ny[ACC_W-1] ? ACC_W'(-r_ny) : ACC_W'(r_ny);
    assign den_abs = r_den[DEN_W-1] ? DEN_W'(-r_den) : DEN_W'(r_den);
    assign gex     = r_rx >= r_d;
    assign gey     = r_ry >= r_d;

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.cap)
            CAP_S0:  r_s0 <= wdata;
            CAP_S1:  r_s1 <= wdata;
            CAP_S2:  r_s2 <= wdata;
            CAP_C0:  r_c0 <= wdata;
            CAP_C1:  r_c1 <= wdata;
            CAP_C2:  r_c2 <= wdata;
            default: ;
        endcase

        unique case (i_cmd.ld)
            LD_EA: r_ea <= rd_c;
            LD_EB: r_eb <= rd_c;
            LD_CCW_S: begin
                r_ea <= r_s0;
                r_eb <= r_s1;
                r_pk <= r_s2;
            end
            LD_CCW_C: begin
                r_ea <= r_c0;
                r_eb <= r_c1;
                r_pk <= r_c2;
            end
            LD_PK: r_pk <= cur_rd;
            LD_PI: begin
                r_pi  <= r_pk;
                r_iin <= r_kin;
            end
            default: ;
        endcase

        if (i_cmd.mac_en) begin
            if (!i_cmd.mac_sec) begin
                r_acc <= ACC_W'(prod);
            end else begin
                unique case (i_cmd.mop)
                    M_SIDE:  r_kin <= res[ACC_W-1];
                    M_P12:   r_p12 <= res[OPA_W-1:0];
                    M_P34:   r_p34 <= res[OPA_W-1:0];
                    M_DEN:   r_den <= res[DEN_W-1:0];
                    M_NX:    r_nx  <= res;
                    M_NY:    r_ny  <= res;
                    default: ;
                endcase
            end
        end

        if (i_cmd.div_start) begin
            r_rx   <= DIV_W'(nx_abs);
            r_ry   <= DIV_W'(ny_abs);
            r_d    <= DIV_W'(den_abs) << (Q_W - 1);
            r_qx   <= '0;
            r_qy   <= '0;
            r_negx <= r_nx[ACC_W-1] ^ r_den[DEN_W-1];
            r_negy <= r_ny[ACC_W-1] ^ r_den[DEN_W-1];
            r_dcnt <= DCNT_W'(Q_W);
        end else if (r_dcnt != '0) begin
            r_rx   <= gex ? r_rx - r_d : r_rx;
            r_ry   <= gey ? r_ry - r_d : r_ry;
            r_qx   <= {r_qx[Q_W-2:0], gex};
            r_qy   <= {r_qy[Q_W-2:0], gey};
            r_d    <= r_d >> 1;
            r_dcnt <= r_dcnt - DCNT_W'(1);
        end

        if (i_cmd.out_load) begin
            r_ox    <= (i_cmd.out_stat == ST_OK) ? cur_rd.x : '0;
            r_oy    <= (i_cmd.out_stat == ST_OK) ? cur_rd.y : '0;
            r_olast <= i_cmd.out_last;
            r_ostat <= i_cmd.out_stat;
        end
    end

    assign o_stat = '{kin: r_kin, iin: r_iin, den_zero: (r_den == '0),
                      div_done: (r_dcnt == '0)};
    assign o_x_res    = r_ox;
    assign o_y_res    = r_oy;
    assign o_last_res = r_olast;
    assign o_status   = r_ostat;
endmodule

// File: sv/pc_controller.sv
module pc_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_operation,
    input  logic              i_in_last,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  pc_pkg::t_dp_stat  i_stat,
    output pc_pkg::t_dp_cmd   o_cmd
);
    import pc_pkg::*;

    t_state r_state, n_state, r_ret, n_ret;
    logic [VC_W-1:0] r_scnt, n_scnt, r_n, n_n, r_i, n_i, r_m, n_m;
    logic [CC_W-1:0] r_ccnt, n_ccnt, r_e, n_e;
    logic [3:0]      r_k, n_k;
    logic r_ovf, n_ovf, r_curb, n_curb, r_revs, n_revs, r_revc, n_revc;
    logic r_ovalid, n_ovalid, r_olast, n_olast;
    t_status r_stat, n_stat;

    logic [CC_W-1:0] e_next, c_a, c_b;
    logic [VC_W-1:0] i_next, v_j, v_map;
    logic            m_full, accept;

    assign e_next = (r_e + CC_W'(1) == r_ccnt) ? '0 : r_e + CC_W'(1);
    assign c_a    = r_revc ? r_ccnt - CC_W'(1) - r_e : r_e;
    assign c_b    = r_revc ? r_ccnt - CC_W'(1) - e_next : e_next;
    assign i_next = (r_i + VC_W'(1) == r_n) ? '0 : r_i + VC_W'(1);
    assign v_j    = (r_state == S_EB) ? '0 : i_next;
    assign v_map  = (r_e == '0 && r_revs) ? r_n - VC_W'(1) - v_j : v_j;
    assign m_full = r_m >= VC_W'(MAX_VERTS);
    assign accept = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_scnt   <= '0;
            r_ccnt   <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_scnt   <= n_scnt;
            r_ccnt   <= n_ccnt;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
        end
        r_ret   <= n_ret;
        r_n     <= n_n;
        r_i     <= n_i;
        r_m     <= n_m;
        r_e     <= n_e;
        r_k     <= n_k;
        r_curb  <= n_curb;
        r_revs  <= n_revs;
        r_revc  <= n_revc;
        r_olast <= n_olast;
        r_stat  <= n_stat;
    end

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_scnt   = r_scnt;
        n_ccnt   = r_ccnt;
        n_ovf    = r_ovf;
        n_n      = r_n;
        n_i      = r_i;
        n_m      = r_m;
        n_e      = r_e;
        n_k      = r_k;
        n_curb   = r_curb;
        n_revs   = r_revs;
        n_revc   = r_revc;
        n_ovalid = r_ovalid;
        n_olast  = r_olast;
        n_stat   = r_stat;

        o_cmd           = '0;
        o_cmd.wsrc      = WS_IN;
        o_cmd.cap       = CAP_NONE;
        o_cmd.ld        = LD_NONE;
        o_cmd.mop       = M_SIDE;
        o_cmd.out_stat  = ST_OK;
        o_cmd.cur_b     = r_curb;
        o_cmd.raddr     = v_map[VA_W-1:0];
        o_cmd.caddr     = (r_state == S_EA) ? c_b[CA_W-1:0] : c_a[CA_W-1:0];
        o_cmd.waddr     = r_m[VA_W-1:0];
        o_cmd.cwaddr    = r_ccnt[CA_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_in_operation) begin
                        if (r_scnt < VC_W'(MAX_VERTS)) begin
                            o_cmd.wr_a  = 1'b1;
                            o_cmd.waddr = r_scnt[VA_W-1:0];
                            o_cmd.cap   = (r_scnt == VC_W'(0)) ? CAP_S0 :
                                          (r_scnt == VC_W'(1)) ? CAP_S1 :
                                          (r_scnt == VC_W'(2)) ? CAP_S2 : CAP_NONE;
                            n_scnt = r_scnt + VC_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        if (r_ccnt < CC_W'(MAX_CLIP)) begin
                            o_cmd.wr_c = 1'b1;
                            o_cmd.cap  = (r_ccnt == CC_W'(0)) ? CAP_C0 :
                                         (r_ccnt == CC_W'(1)) ? CAP_C1 :
                                         (r_ccnt == CC_W'(2)) ? CAP_C2 : CAP_NONE;
                            n_ccnt = r_ccnt + CC_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                        if (i_in_last) begin
                            n_state = S_CHK;
                        end
                    end
                end
            end
            S_CHK: begin
                n_n = r_scnt;
                if (r_ovf) begin
                    n_stat  = ST_OVF;
                    n_state = S_OST;
                end else if (r_scnt < VC_W'(3) || r_ccnt < CC_W'(3)) begin
                    n_stat  = ST_SHORT;
                    n_state = S_OST;
                end else begin
                    o_cmd.ld = LD_CCW_S;
                    n_k      = '0;
                    n_ret    = S_REVS;
                    n_state  = S_SIDE;
                end
            end
            S_SIDE: begin
                o_cmd.mac_en  = 1'b1;
                o_cmd.mac_sec = r_k[0];
                o_cmd.mop     = M_SIDE;
                n_k           = r_k + 4'd1;
                if (r_k[0]) begin
                    n_k     = '0;
                    n_state = r_ret;
                end
            end
            S_REVS: begin
                n_revs   = !i_stat.kin;
                o_cmd.ld = LD_CCW_C;
                n_ret    = S_REVC;
                n_state  = S_SIDE;
            end
            S_REVC: begin
                n_revc  = !i_stat.kin;
                n_e     = '0;
                n_curb  = 1'b0;
                n_state = S_EDGE;
            end
            S_EDGE: begin
                n_m     = '0;
                n_i     = '0;
                n_state = S_EA;
            end
            S_EA: begin
                o_cmd.ld = LD_EA;
                n_state  = S_EB;
            end
            S_EB: begin
                o_cmd.ld = LD_EB;
                n_state  = (r_n == '0) ? S_EEND : S_P0;
            end
            S_P0: begin
                o_cmd.ld = LD_PK;
                n_ret    = S_V;
                n_state  = S_SIDE;
            end
            S_V: begin
                o_cmd.ld = LD_PI;
                n_state  = S_VK;
            end
            S_VK: begin
                o_cmd.ld = LD_PK;
                n_ret    = S_DEC;
                n_state  = S_SIDE;
            end
            S_DEC: begin
                if (i_stat.iin != i_stat.kin) begin
                    if (m_full) begin
                        n_stat  = ST_OVF;
                        n_state = S_OST;
                    end else begin
                        n_k     = '0;
                        n_state = S_XMAC;
                    end
                end else begin
                    n_state = S_KEEP;
                end
            end
            S_XMAC: begin
                o_cmd.mac_en  = 1'b1;
                o_cmd.mac_sec = r_k[0];
                unique case (r_k[3:1])
                    3'd0:    o_cmd.mop = M_P12;
                    3'd1:    o_cmd.mop = M_P34;
                    3'd2:    o_cmd.mop = M_DEN;
                    3'd3:    o_cmd.mop = M_NX;
                    default: o_cmd.mop = M_NY;
                endcase
                n_k = r_k + 4'd1;
                if (r_k == 4'd9) begin
                    n_state = S_XDIV_CHK;
                end
            end
            S_XDIV_CHK: begin
                if (i_stat.den_zero) begin
                    o_cmd.wr_a = r_curb;
                    o_cmd.wr_b = !r_curb;
                    o_cmd.wsrc = WS_PK;
                    n_m        = r_m + VC_W'(1);
                    n_state    = S_KEEP;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_XDIV;
                end
            end
            S_XDIV: begin
                if (i_stat.div_done) begin
                    n_state = S_XW;
                end
            end
            S_XW: begin
                o_cmd.wr_a = r_curb;
                o_cmd.wr_b = !r_curb;
                o_cmd.wsrc = WS_XP;
                n_m        = r_m + VC_W'(1);
                n_state    = S_KEEP;
            end
            S_KEEP: begin
                if (i_stat.kin && m_full) begin
                    n_stat  = ST_OVF;
                    n_state = S_OST;
                end else begin
                    if (i_stat.kin) begin
                        o_cmd.wr_a = r_curb;
                        o_cmd.wr_b = !r_curb;
                        o_cmd.wsrc = WS_PK;
                        n_m        = r_m + VC_W'(1);
                    end
                    n_i     = r_i + VC_W'(1);
                    n_state = (r_i + VC_W'(1) == r_n) ? S_EEND : S_V;
                end
            end
            S_EEND: begin
                n_n    = r_m;
                n_curb = !r_curb;
                if (r_e + CC_W'(1) == r_ccnt) begin
                    n_state = S_FIN;
                end else begin
                    n_e     = r_e + CC_W'(1);
                    n_state = S_EDGE;
                end
            end
            S_FIN: begin
                n_i = '0;
                if (r_n == '0) begin
                    n_stat  = ST_EMPTY;
                    n_state = S_OST;
                end else begin
                    n_state = S_ORD;
                end
            end
            S_ORD: begin
                o_cmd.raddr = r_i[VA_W-1:0];
                n_state     = S_OLD;
            end
            S_OLD: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_stat = ST_OK;
                o_cmd.out_last = (r_i + VC_W'(1) == r_n);
                n_olast        = (r_i + VC_W'(1) == r_n);
                n_ovalid       = 1'b1;
                n_state        = S_OWT;
            end
            S_OST: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_stat = r_stat;
                o_cmd.out_last = 1'b1;
                n_olast        = 1'b1;
                n_ovalid       = 1'b1;
                n_state        = S_OWT;
            end
            S_OWT: begin
                if (i_out_ready) begin
                    n_ovalid = 1'b0;
                    if (r_olast) begin
                        n_scnt  = '0;
                        n_ccnt  = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + VC_W'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
endmodule

// File: sv/polygon_clipper_unit.sv
// Channel   Dir   Payload                          Beat taken when
// i_in      in    operation, x, y, last            valid and ready high
// o_out     out   x_res, y_res, last_res, status   valid and ready high
//
// Loading takes one vertex beat per cycle; ready is high only while loading.
// A clipping run takes each vertex against each clip edge in turn. Each
// crossing point takes 10 shared multiply steps, the 18-step divider and
// the write of the point, after a zero check that can skip the divider.
// Each result beat goes through the registered read of the store (S_ORD, S_OLD) and is held in S_OWT until taken.
// Reset is synchronous and active low; stalls on o_out hold the run.
module polygon_clipper_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pc_in_if.sink    i_in,
    pc_out_if.source o_out
);
    import pc_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    pc_controller u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid),
        .i_in_operation(i_in.operation),
        .i_in_last(i_in.last),
        .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid),
        .i_out_ready(o_out.ready),
        .i_stat(stat),
        .o_cmd(cmd)
    );

    pc_datapath u_dp (
        .i_clk(i_clk),
        .i_cmd(cmd),
        .i_x(i_in.x),
        .i_y(i_in.y),
        .o_stat(stat),
        .o_x_res(o_out.x_res),
        .o_y_res(o_out.y_res),
        .o_last_res(o_out.last_res),
        .o_status(o_out.status)
    );
endmodule

// File: sv/pc_checker.sv
module pc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [pc_pkg::COORD_W-1:0] i_x_res,
    input logic signed [pc_pkg::COORD_W-1:0] i_y_res,
    input logic                              i_last_res,
    input logic [1:0]                        i_status
);
    import pc_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result beat dropped while stalled.");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("Input taken while a result is pending.");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_last_res)
        else $error("Status beat is not the last of its run.");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_x_res == '0 && i_y_res == '0)
        else $error("Status beat carries coordinates.");
endmodule

bind polygon_clipper_unit pc_checker u_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_x_res(o_out.x_res),
    .i_y_res(o_out.y_res),
    .i_last_res(o_out.last_res),
    .i_status(o_out.status)
);

// File: bench/polygon_clipper_unit_test.sv
`timescale 1ns / 1ps

module polygon_clipper_unit_test;
    import pc_pkg::*;

    localparam int N_VERTS = MAX_VERTS;
    localparam int N_CLIP  = MAX_CLIP;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
        t_status            status;
    } t_clip_out;

    logic i_clk;
    logic i_rst_n;

    pc_in_if  in_ch ();
    pc_out_if out_ch ();

    polygon_clipper_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Shadow of the block's vertex stores.
    t_pt         subj_pts[$];
    t_pt         clip_pts[$];
    logic        load_ovf;
    t_clip_out   expected_verts[$];
    int          mismatches;
    int          beats_sent;
    int          beats_seen;
    int          runs_done;
    int          send_idle_pct;
    int          recv_idle_pct;

    function automatic logic winds_ccw(t_pt p0, t_pt p1, t_pt p2);
        longint c;
        c = (longint'(p1.x) - p0.x) * (longint'(p2.y) - p0.y)
          - (longint'(p2.x) - p0.x) * (longint'(p1.y) - p0.y);
        return c >= 0;
    endfunction

    function automatic longint edge_side(t_pt a, t_pt b, t_pt p);
        return (longint'(b.x) - a.x) * (longint'(p.y) - a.y)
             - (longint'(b.y) - a.y) * (longint'(p.x) - a.x);
    endfunction

    function automatic logic signed [15:0] sat16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic t_pt crossing(t_pt a, t_pt b, t_pt c, t_pt d);
        longint x1, y1, x2, y2, x3, y3, x4, y4, p12, p34, den, nx, ny;
        t_pt r;
        x1 = a.x; y1 = a.y; x2 = b.x; y2 = b.y;
        x3 = c.x; y3 = c.y; x4 = d.x; y4 = d.y;
        p12 = x1 * y2 - y1 * x2;
        p34 = x3 * y4 - y3 * x4;
        den = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
        if (den == 0) return d;
        nx = p12 * (x3 - x4) - (x1 - x2) * p34;
        ny = p12 * (y3 - y4) - (y1 - y2) * p34;
        r.x = sat16(nx / den);
        r.y = sat16(ny / den);
        return r;
    endfunction

    task automatic push_status(t_status st);
        t_clip_out o;
        o.x = '0;
        o.y = '0;
        o.last = 1'b1;
        o.status = st;
        expected_verts = {expected_verts, o};
    endtask

    task automatic predict_clip();
        t_pt cur[$];
        t_pt nxt[$];
        t_pt ea, eb, pi, pk;
        t_clip_out o;
        logic iin, kin, ovf;
        int n;
        ovf = 1'b0;
        runs_done++;
        if (load_ovf) begin
            push_status(ST_OVF);
            return;
        end
        if (subj_pts.size() < 3 || clip_pts.size() < 3) begin
            push_status(ST_SHORT);
            return;
        end
        cur = subj_pts;
        if (winds_ccw(cur[0], cur[1], cur[2])) cur.reverse();
        if (winds_ccw(clip_pts[0], clip_pts[1], clip_pts[2])) clip_pts.reverse();
        for (int e = 0; e < clip_pts.size() && !ovf; e++) begin
            ea = clip_pts[e];
            eb = clip_pts[(e + 1) % clip_pts.size()];
            nxt = {};
            n = cur.size();
            for (int i = 0; i < n && !ovf; i++) begin
                pi = cur[i];
                pk = cur[(i + 1) % n];
                iin = edge_side(ea, eb, pi) < 0;
                kin = edge_side(ea, eb, pk) < 0;
                if (iin != kin) begin
                    if (nxt.size() >= N_VERTS) ovf = 1'b1;
                    else nxt = {nxt, crossing(ea, eb, pi, pk)};
                end
                if (kin && !ovf) begin
                    if (nxt.size() >= N_VERTS) ovf = 1'b1;
                    else nxt = {nxt, pk};
                end
            end
            cur = nxt;
        end
        if (ovf) push_status(ST_OVF);
        else if (cur.size() == 0) push_status(ST_EMPTY);
        else begin
            foreach (cur[i]) begin
                o.x = cur[i].x;
                o.y = cur[i].y;
                o.last = (i == cur.size() - 1);
                o.status = ST_OK;
                expected_verts = {expected_verts, o};
            end
        end
    endtask

    task automatic send_vertex(logic op, logic signed [15:0] x, logic signed [15:0] y,
                               logic last);
        t_pt p;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.x         <= x;
        in_ch.y         <= y;
        in_ch.last      <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        beats_sent++;
        p.x = x;
        p.y = y;
        if (!op) begin
            if (subj_pts.size() < N_VERTS) subj_pts = {subj_pts, p};
            else load_ovf = 1'b1;
        end else begin
            if (clip_pts.size() < N_CLIP) clip_pts = {clip_pts, p};
            else load_ovf = 1'b1;
            if (last) begin
                predict_clip();
                subj_pts = {};
                clip_pts = {};
                load_ovf = 1'b0;
            end
        end
    endtask

    // Sends a whole polygon pair; the clip last beat closes it.
    task automatic send_pair(t_pt s[$], t_pt c[$]);
        foreach (s[i]) send_vertex(1'b0, s[i].x, s[i].y, 1'($urandom_range(1)));
        foreach (c[i]) send_vertex(1'b1, c[i].x, c[i].y, i == c.size() - 1);
    endtask

    function automatic t_pt mk(int x, int y);
        t_pt p;
        p.x = 16'(x);
        p.y = 16'(y);
        return p;
    endfunction

    function automatic t_pt rnd_pt(int span);
        return mk(int'($urandom_range(2 * span)) - span,
                  int'($urandom_range(2 * span)) - span);
    endfunction

    always @(posedge i_clk) begin
        t_clip_out w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            beats_seen++;
            if (expected_verts.size() == 0) begin
                mismatches++;
                $display("%t unexpected beat x=%0d y=%0d last=%0b status=%0d", $time,
                         out_ch.x_res, out_ch.y_res, out_ch.last_res, out_ch.status);
            end else begin
                w = expected_verts.pop_front();
                if (out_ch.x_res !== w.x || out_ch.y_res !== w.y
                    || out_ch.last_res !== w.last || out_ch.status !== w.status) begin
                    mismatches++;
                    $display("%t expected x=%0d y=%0d last=%0b status=%0d", $time,
                             w.x, w.y, w.last, w.status);
                    $display("%t actual   x=%0d y=%0d last=%0b status=%0d", $time,
                             out_ch.x_res, out_ch.y_res, out_ch.last_res, out_ch.status);
                end
            end
        end
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic test_directed();
        t_pt s[$];
        t_pt c[$];
        // A clockwise square clipped by a counter-clockwise triangle.
        s = '{mk(-160, -160), mk(-160, 160), mk(160, 160), mk(160, -160)};
        c = '{mk(0, -320), mk(320, 320), mk(-320, 320)};
        send_pair(s, c);
        // Extreme coordinates and a counter-clockwise subject.
        s = '{mk(-32768, -32768), mk(32767, -32768), mk(32767, 32767)};
        c = '{mk(32767, 32767), mk(-32768, 32767), mk(-32768, -32768)};
        send_pair(s, c);
        // Disjoint polygons give an empty result.
        s = '{mk(1000, 1000), mk(1000, 1100), mk(1100, 1100)};
        c = '{mk(-100, -100), mk(-100, 0), mk(0, 0)};
        send_pair(s, c);
        // Too few subject vertices, then too few clip vertices.
        s = '{mk(1, 2), mk(3, 4)};
        c = '{mk(0, 0), mk(0, 16), mk(16, 0)};
        send_pair(s, c);
        s = '{mk(0, 0), mk(0, 16), mk(16, 0)};
        c = '{mk(0, 0), mk(0, 16)};
        send_pair(s, c);
        // A subject vertex between clip vertices is appended to the subject.
        send_vertex(1'b0, -80, -80, 1'b0);
        send_vertex(1'b0, -80, 80, 1'b0);
        send_vertex(1'b1, -200, -200, 1'b0);
        send_vertex(1'b0, 80, 80, 1'b1);
        send_vertex(1'b1, -200, 200, 1'b0);
        send_vertex(1'b1, 200, 200, 1'b1);
    endtask

    task automatic test_store_overflow();
        t_pt s[$];
        t_pt c[$];
        // Subject store overrun by one vertex.
        for (int i = 0; i < N_VERTS + 1; i++) s = {s, rnd_pt(100)};
        c = '{mk(0, 0), mk(0, 50), mk(50, 0)};
        send_pair(s, c);
        // Clip store overrun.
        s = '{mk(0, 0), mk(0, 50), mk(50, 0)};
        c = {};
        for (int i = 0; i < N_CLIP + 2; i++) c = {c, rnd_pt(100)};
        send_pair(s, c);
    endtask

    task automatic test_random(int items);
        t_pt s[$];
        t_pt c[$];
        int ns, nc, span, sent0;
        sent0 = beats_sent;
        while (beats_sent - sent0 < items) begin
            span = ($urandom_range(3) == 0) ? 32767 : $urandom_range(800) + 20;
            ns = $urandom_range(9) + 1;
            nc = $urandom_range(6) + 1;
            if ($urandom_range(9) == 0) ns = $urandom_range(N_VERTS - 40) + 40;
            s = {};
            c = {};
            for (int i = 0; i < ns; i++) s = {s, rnd_pt(span)};
            for (int i = 0; i < nc; i++) c = {c, rnd_pt(span)};
            send_pair(s, c);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_verts.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    initial begin
        in_ch.valid     <= 1'b0;
        in_ch.operation <= 1'b0;
        in_ch.x         <= '0;
        in_ch.y         <= '0;
        in_ch.last      <= 1'b0;
        i_rst_n         <= 1'b0;
        mismatches = 0;
        beats_sent = 0;
        beats_seen = 0;
        runs_done = 0;
        load_ovf = 1'b0;
        send_idle_pct = 22;
        recv_idle_pct = 49;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_store_overflow();
        test_random(100);
        send_idle_pct = 49;
        recv_idle_pct = 22;
        test_random(100);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(120);
        drain();
        $display("Sent %0d vertex beats in %0d clipping runs; checked %0d result beats.",
                 beats_sent, runs_done, beats_seen);
        if (mismatches == 0) begin
            $display("polygon_clipper_unit test passed");
        end else begin
            $display("polygon_clipper_unit test failed");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("polygon_clipper_unit test failed");
        $finish;
    end
endmodule
